// File: hdl/ivm_pkg.sv
// Shared types, constants and helpers for the impact voice mixer.
package ivm_pkg;

    localparam int VOICE_SLOTS_DEF = 256;

    localparam int CFG_IDX_W = 2;
    localparam int MAXV_W    = 9;

    localparam logic [15:0]       GAIN_RST   = 16'd256;
    localparam logic [15:0]       THRESH_RST = 16'd66;
    localparam logic [MAXV_W-1:0] MAXV_RST   = 9'd200;
    localparam logic [15:0]       NOISE_SEED = 16'hACE1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN       = 2'd0,
        REG_THRESHOLD  = 2'd1,
        REG_MAX_VOICES = 2'd2
    } t_reg_idx;

    // one voice slot: coefficients, volume and filter state
    typedef struct packed {
        logic [15:0]        volume;
        logic [15:0]        decay;
        logic [15:0]        cut;
        logic [15:0]        bw;
        logic signed [23:0] lpf;
        logic signed [23:0] bpf;
    } t_voice;

    // controller to datapath commands
    typedef struct packed {
        logic add;
        logic tick;
        logic rd_voice;
        logic step1;
        logic step2;
        logic step3;
        logic step4;
        logic step5;
        logic step6;
        logic step7;
        logic finish;
        logic cp_rd;
        logic cp_wr;
        logic load_out;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic empty;
        logic retire;
        logic last_eq;
        logic more;
        logic out_free;
    } t_stat;

    // clamp to signed 24 bits
    function automatic logic signed [23:0] sat24(input logic signed [34:0] x);
        logic signed [23:0] r;
        if (x > 35'sd8388607) begin
            r = 24'sh7FFFFF;
        end else if (x < -35'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = x[23:0];
        end
        return r;
    endfunction

endpackage

// File: hdl/ivm_if.sv
// Channel interfaces: input item, result item and configuration write.
interface ivm_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] volume;
    logic [15:0] decay;
    logic [15:0] cut;
    logic [15:0] bw;
    modport source (output valid, kind, volume, decay, cut, bw, input ready);
    modport sink   (input valid, kind, volume, decay, cut, bw, output ready);
endinterface

interface ivm_res_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] mixed_sample;
    logic               accepted;
    logic [8:0]         active_voices;
    modport source (output valid, mixed_sample, accepted, active_voices, input ready);
    modport sink   (input valid, mixed_sample, accepted, active_voices, output ready);
endinterface

interface ivm_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/ivm_ctrl.sv
// Sequencing state machine for add and tick words.
module ivm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_kind,
    output logic          o_in_ready,
    input  ivm_pkg::t_stat i_stat,
    output ivm_pkg::t_cmd  o_cmd
);
    import ivm_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_READ = 13'b0000000000010,
        S_M1   = 13'b0000000000100,
        S_M2   = 13'b0000000001000,
        S_M3   = 13'b0000000010000,
        S_M4   = 13'b0000000100000,
        S_M5   = 13'b0000001000000,
        S_M6   = 13'b0000010000000,
        S_M7   = 13'b0000100000000,
        S_FIN  = 13'b0001000000000,
        S_CPRD = 13'b0010000000000,
        S_CPWR = 13'b0100000000000,
        S_DONE = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (!i_in_kind) begin
                        o_cmd.add = 1'b1;
                        n_state   = S_DONE;
                    end else begin
                        o_cmd.tick = 1'b1;
                        n_state    = i_stat.empty ? S_DONE : S_READ;
                    end
                end
            end
            S_READ: begin
                o_cmd.rd_voice = 1'b1;
                n_state        = S_M1;
            end
            S_M1: begin o_cmd.step1 = 1'b1; n_state = S_M2; end
            S_M2: begin o_cmd.step2 = 1'b1; n_state = S_M3; end
            S_M3: begin o_cmd.step3 = 1'b1; n_state = S_M4; end
            S_M4: begin o_cmd.step4 = 1'b1; n_state = S_M5; end
            S_M5: begin o_cmd.step5 = 1'b1; n_state = S_M6; end
            S_M6: begin o_cmd.step6 = 1'b1; n_state = S_M7; end
            S_M7: begin o_cmd.step7 = 1'b1; n_state = S_FIN; end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                priority if (i_stat.retire && !i_stat.last_eq) begin
                    n_state = S_CPRD;
                end else if (i_stat.more) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_CPRD: begin
                o_cmd.cp_rd = 1'b1;
                n_state     = S_CPWR;
            end
            S_CPWR: begin
                // the moved voice sits below the new count, so it is stepped next
                o_cmd.cp_wr = 1'b1;
                n_state     = S_READ;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: hdl/ivm_dp.sv
// Voice store, filter arithmetic, mix accumulator and result register.
module ivm_dp #(
    parameter int VOICE_SLOTS = ivm_pkg::VOICE_SLOTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ivm_pkg::t_cmd        i_cmd,
    output ivm_pkg::t_stat       o_stat,
    input  logic [15:0]          i_volume,
    input  logic [15:0]          i_decay,
    input  logic [15:0]          i_cut,
    input  logic [15:0]          i_bw,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic signed [23:0]   o_mixed_sample,
    output logic                 o_accepted,
    output logic [8:0]           o_active_voices
);
    import ivm_pkg::*;

    localparam int AW = (VOICE_SLOTS > 1) ? $clog2(VOICE_SLOTS) : 1;
    localparam int CW = $clog2(VOICE_SLOTS + 1);
    localparam int MW = (CW > MAXV_W) ? CW : MAXV_W;

    t_voice r_mem [VOICE_SLOTS];
    t_voice r_rd;

    logic [CW-1:0]       r_count, r_idx;
    logic [15:0]         r_gain, r_thr;
    logic [MAXV_W-1:0]   r_max;
    logic [15:0]         r_noise, n_noise;

    logic [15:0]         r_volm;
    logic signed [40:0]  r_pa, r_pb, r_po;
    logic signed [23:0]  r_lpf, r_bpf, r_sum;
    logic signed [26:0]  r_bwt;
    logic signed [28:0]  r_drive;
    logic signed [45:0]  r_pc;
    logic signed [41:0]  r_pg;
    logic                r_acc;

    logic                add_ok;
    logic [MW-1:0]       count_ext;
    logic                we;
    logic [AW-1:0]       waddr, raddr;
    t_voice              wdata, stepped;

    assign count_ext = MW'(r_count);
    assign add_ok    = (count_ext < MW'(r_max)) && (r_count < CW'(VOICE_SLOTS));

    // status toward the controller
    assign o_stat.empty    = (r_count == '0);
    assign o_stat.retire   = (r_volm < r_thr);
    assign o_stat.last_eq  = (CW'(r_count - 1'b1) == r_idx);
    assign o_stat.more     = (CW'(r_idx + 1'b1) < r_count);
    assign o_stat.out_free = !o_out_valid || i_out_ready;

    // LFSR taps 16,14,13,11, shifting right
    assign n_noise = {r_noise[0] ^ r_noise[2] ^ r_noise[3] ^ r_noise[5], r_noise[15:1]};

    always_comb begin
        stepped        = r_rd;
        stepped.volume = r_volm;
        stepped.lpf    = r_lpf;
        stepped.bpf    = r_bpf;
    end

    // store write and read port select
    always_comb begin
        we    = 1'b0;
        waddr = r_idx[AW-1:0];
        wdata = stepped;
        raddr = i_cmd.cp_rd ? r_count[AW-1:0] : r_idx[AW-1:0];
        priority if (i_cmd.add) begin
            we    = add_ok;
            waddr = r_count[AW-1:0];
            wdata = '{volume: i_volume, decay: i_decay, cut: i_cut, bw: i_bw,
                      lpf: '0, bpf: '0};
        end else if (i_cmd.finish) begin
            we = !o_stat.retire;
        end else if (i_cmd.cp_wr) begin
            we    = 1'b1;
            wdata = r_rd;
        end else begin
            we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (i_cmd.rd_voice || i_cmd.cp_rd) begin
            r_rd <= r_mem[raddr];
        end
    end

    // control state: count, index, noise and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
            r_noise <= NOISE_SEED;
            r_gain  <= GAIN_RST;
            r_thr   <= THRESH_RST;
            r_max   <= MAXV_RST;
        end else begin
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_index))
                    REG_GAIN:       r_gain <= i_cfg_data;
                    REG_THRESHOLD:  r_thr  <= i_cfg_data;
                    REG_MAX_VOICES: r_max  <= i_cfg_data[MAXV_W-1:0];
                    default:        r_gain <= r_gain;
                endcase
            end
            if (i_cmd.add && add_ok) begin
                r_count <= CW'(r_count + 1'b1);
            end
            if (i_cmd.tick) begin
                r_idx <= '0;
            end
            if (i_cmd.step1) begin
                r_noise <= n_noise;
            end
            if (i_cmd.finish) begin
                if (o_stat.retire) begin
                    r_count <= CW'(r_count - 1'b1);
                end else begin
                    r_idx <= CW'(r_idx + 1'b1);
                end
            end
        end
    end

    // filter arithmetic, spread across the step commands and finish
    always_ff @(posedge i_clk) begin
        if (i_cmd.add || i_cmd.tick) begin
            r_sum <= '0;
            r_acc <= i_cmd.add && add_ok;
        end
        if (i_cmd.step1) begin
            r_volm <= 16'((32'(r_rd.volume) * 32'(r_rd.decay)) >> 16);
            r_pa   <= $signed({1'b0, r_rd.cut}) * r_rd.bpf;
            r_pb   <= $signed({1'b0, r_rd.bw}) * r_rd.bpf;
        end
        if (i_cmd.step2) begin
            r_lpf <= sat24(35'(r_rd.lpf) + 35'($signed(r_pa[40:16])));
            r_bwt <= $signed(r_pb[40:14]);
        end
        if (i_cmd.step3) begin
            r_drive <= 29'($signed({r_noise, 5'b0})) - 29'(r_lpf) - 29'(r_bwt);
        end
        if (i_cmd.step4) begin
            r_pc <= $signed({1'b0, r_rd.cut}) * r_drive;
        end
        if (i_cmd.step5) begin
            r_bpf <= sat24(35'(r_rd.bpf) + 35'($signed(r_pc[45:16])));
        end
        if (i_cmd.step6) begin
            r_po <= r_bpf * $signed({1'b0, r_volm});
        end
        if (i_cmd.step7) begin
            r_pg <= $signed(r_po[40:16]) * $signed({1'b0, r_gain});
        end
        if (i_cmd.finish) begin
            r_sum <= sat24(35'(r_sum) + 35'($signed(r_pg[41:8])));
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_mixed_sample  <= r_sum;
            o_accepted      <= r_acc;
            o_active_voices <= count_ext[8:0];
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(VOICE_SLOTS))
        else $error("voice count above slot count");

    a_step_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (r_idx < r_count))
        else $error("stepped voice outside the pool");

    a_move_from_above: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cp_rd |-> (r_count > r_idx))
        else $error("moved voice not above retired slot");

    a_noise_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_noise != 16'd0)
        else $error("noise register stuck at zero");
`endif

endmodule

// File: hdl/impact_voice_mixer.sv
// An add word goes from idle to the done state, which loads the result register.
// A tick word reads each voice from the store and runs the multiply chain on it;
// a retired voice other than the last is replaced by a move from the top slot.
// One word in work at a time; the next is taken once its result is loaded.
// Reset: voice count 0, noise register 0xACE1, gain 256, threshold 66, max 200;
// the voice store is not cleared.
module impact_voice_mixer #(
    parameter int VOICE_SLOTS = ivm_pkg::VOICE_SLOTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ivm_in_if.sink     i_in,
    ivm_res_if.source  o_res,
    ivm_cfg_if.sink    i_cfg
);
    import ivm_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign i_cfg.ready = 1'b1;

    ivm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_kind  (i_in.kind),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ivm_dp #(
        .VOICE_SLOTS (VOICE_SLOTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_volume        (i_in.volume),
        .i_decay         (i_in.decay),
        .i_cut           (i_in.cut),
        .i_bw            (i_in.bw),
        .i_cfg_we        (i_cfg.valid),
        .i_cfg_index     (i_cfg.index),
        .i_cfg_data      (i_cfg.data),
        .i_out_ready     (o_res.ready),
        .o_out_valid     (o_res.valid),
        .o_mixed_sample  (o_res.mixed_sample),
        .o_accepted      (o_res.accepted),
        .o_active_voices (o_res.active_voices)
    );

endmodule

// File: tb/ivm_mix_checker.sv
// Watches the mixer channels, predicts every result word and compares it.
module ivm_mix_checker (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ivm_in_if         i_in,
    ivm_res_if        i_res,
    ivm_cfg_if        i_cfg,
    output int        o_fails,
    output int        o_pending
);
    import ivm_pkg::*;

    localparam int SLOTS = 256;

    typedef struct {
        logic signed [23:0] sample;
        logic               taken;
        logic [8:0]         voices;
    } t_mix_word;

    // predictor copy of the voice pool
    logic [15:0]        pool_vol   [SLOTS];
    logic [15:0]        pool_decay [SLOTS];
    logic [15:0]        pool_cut   [SLOTS];
    logic [15:0]        pool_bw    [SLOTS];
    longint             pool_lpf   [SLOTS];
    longint             pool_bpf   [SLOTS];
    int                 pool_count;
    logic [15:0]        lfsr;
    logic [15:0]        gain_reg;
    logic [15:0]        thresh_reg;
    logic [8:0]         maxv_reg;

    t_mix_word          mix_queue[$];

    function automatic longint clamp24(longint x);
        if (x > 8388607) return 8388607;
        if (x < -8388608) return -8388608;
        return x;
    endfunction

    // advance the noise register once, return the draw in Q4.20
    function automatic longint next_noise();
        logic fb;
        fb = lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5];
        lfsr = {fb, lfsr[15:1]};
        return longint'($signed(lfsr)) * 32;
    endfunction

    // one voice step: decay, low-pass and band-pass update, scaled output
    function automatic longint voice_out(int s);
        longint vol, drive, band;
        vol = (longint'(pool_vol[s]) * longint'(pool_decay[s])) >>> 16;
        pool_vol[s] = vol[15:0];
        pool_lpf[s] = clamp24(pool_lpf[s] + ((longint'(pool_cut[s]) * pool_bpf[s]) >>> 16));
        drive = next_noise() - pool_lpf[s] - ((pool_bpf[s] * longint'(pool_bw[s])) >>> 14);
        pool_bpf[s] = clamp24(pool_bpf[s] + ((longint'(pool_cut[s]) * drive) >>> 16));
        band = (pool_bpf[s] * vol) >>> 16;
        return (band * longint'(gain_reg)) >>> 8;
    endfunction

    function automatic t_mix_word mix_word(logic kind, logic [15:0] vol, logic [15:0] dec,
                                           logic [15:0] cut, logic [15:0] bw);
        t_mix_word w;
        longint    sum;
        int        i, last;
        sum = 0;
        w.taken = 1'b0;
        if (!kind) begin
            if (pool_count < int'(maxv_reg) && pool_count < SLOTS) begin
                pool_vol[pool_count]   = vol;
                pool_decay[pool_count] = dec;
                pool_cut[pool_count]   = cut;
                pool_bw[pool_count]    = bw;
                pool_lpf[pool_count]   = 0;
                pool_bpf[pool_count]   = 0;
                pool_count++;
                w.taken = 1'b1;
            end
        end else begin
            i = 0;
            while (i < pool_count && i < SLOTS) begin
                sum = clamp24(sum + voice_out(i));
                if (pool_vol[i] < thresh_reg) begin
                    // retire: last voice moves into this slot and steps here
                    last = pool_count - 1;
                    pool_vol[i]   = pool_vol[last];
                    pool_decay[i] = pool_decay[last];
                    pool_cut[i]   = pool_cut[last];
                    pool_bw[i]    = pool_bw[last];
                    pool_lpf[i]   = pool_lpf[last];
                    pool_bpf[i]   = pool_bpf[last];
                    pool_count = last;
                end else begin
                    i++;
                end
            end
        end
        w.sample = sum[23:0];
        w.voices = pool_count[8:0];
        return w;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch on %s at %0t: got %0d, want %0d", field, $time, got, want);
        o_fails++;
    endtask

    always @(posedge i_clk) begin
        t_mix_word want;
        if (!i_rst_n) begin
            pool_count = 0;
            lfsr       = NOISE_SEED;
            gain_reg   = GAIN_RST;
            thresh_reg = THRESH_RST;
            maxv_reg   = MAXV_RST;
            mix_queue.delete();
            o_fails    = 0;
            o_pending  = 0;
        end else begin
            // register writes
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_GAIN:       gain_reg   = i_cfg.data;
                    REG_THRESHOLD:  thresh_reg = i_cfg.data;
                    REG_MAX_VOICES: maxv_reg   = i_cfg.data[8:0];
                    default: ;
                endcase
            end
            // accepted input word
            if (i_in.valid && i_in.ready)
                mix_queue.push_back(mix_word(i_in.kind, i_in.volume, i_in.decay,
                                             i_in.cut, i_in.bw));
            // accepted result word
            if (i_res.valid && i_res.ready) begin
                if (mix_queue.size() == 0) begin
                    report_mismatch("unexpected word", 0, 0);
                end else begin
                    want = mix_queue.pop_front();
                    if (i_res.mixed_sample !== want.sample)
                        report_mismatch("mixed_sample", i_res.mixed_sample, want.sample);
                    if (i_res.accepted !== want.taken)
                        report_mismatch("accepted", i_res.accepted, want.taken);
                    if (i_res.active_voices !== want.voices)
                        report_mismatch("active_voices", i_res.active_voices, want.voices);
                end
            end
            o_pending = mix_queue.size();
        end
    end

endmodule

// File: tb/impact_voice_mixer_test.sv
// Stimulus and verdict for the impact voice mixer.
module impact_voice_mixer_test;
    import ivm_pkg::*;

    localparam int          CYCLE_LIMIT = 3000000;
    localparam logic [1:0]  REG_SPARE   = 2'd3;
    localparam logic        KIND_ADD    = 1'b0;
    localparam logic        KIND_TICK   = 1'b1;

    logic i_clk;
    logic i_rst_n;
    int   fails;
    int   pending;
    int   cycles = 0;
    bit   steady;   // no idling on either side while set

    ivm_in_if  in_ch();
    ivm_res_if res_ch();
    ivm_cfg_if cfg_ch();

    impact_voice_mixer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    ivm_mix_checker chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .i_res     (res_ch),
        .i_cfg     (cfg_ch),
        .o_fails   (fails),
        .o_pending (pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // result backpressure
    always @(negedge i_clk) begin
        res_ch.ready <= steady ? 1'b1 : ($urandom_range(99) >= 28);
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL impact_voice_mixer");
            $finish;
        end
    end

    function automatic bit want_gap();
        return !steady && $urandom_range(99) < 28;
    endfunction

    // present one input word, hold it until taken
    task automatic send_word(logic kind, logic [15:0] vol, logic [15:0] dec,
                             logic [15:0] cut, logic [15:0] bw);
        @(negedge i_clk);
        while (want_gap()) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid  = 1'b1;
        in_ch.kind   = kind;
        in_ch.volume = vol;
        in_ch.decay  = dec;
        in_ch.cut    = cut;
        in_ch.bw     = bw;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic add_voice(logic [15:0] vol, logic [15:0] dec, logic [15:0] cut,
                             logic [15:0] bw);
        send_word(KIND_ADD, vol, dec, cut, bw);
    endtask

    // tick with random junk in the unused fields
    task automatic tick();
        send_word(KIND_TICK, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // wait for all pending results to drain
    task automatic settle();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // register write, only called while settled
    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic random_add();
        logic [15:0] dec;
        dec = ($urandom_range(99) < 70) ? 16'($urandom_range(16'hF000, 16'hFFFF))
                                        : 16'($urandom);
        add_voice(16'($urandom), dec, 16'($urandom), 16'($urandom));
    endtask

    initial begin
        int n, pick;
        steady       = 1'b0;
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.kind   = KIND_ADD;
        in_ch.volume = '0;
        in_ch.decay  = '0;
        in_ch.cut    = '0;
        in_ch.bw     = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_GAIN;
        cfg_ch.data  = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty tick, field extremes, retirement
        tick();
        add_voice(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        add_voice(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_voice(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
        add_voice(16'h8000, 16'h8000, 16'h0001, 16'h4000);
        repeat (4) tick();
        settle();

        // loud, undamped voices drive the sum into saturation
        write_reg(REG_GAIN, 16'hFFFF);
        write_reg(REG_THRESHOLD, 16'h0000);
        write_reg(REG_MAX_VOICES, 16'd2);
        add_voice(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
        add_voice(16'hFFFF, 16'hFFFF, 16'hC000, 16'h0000);
        add_voice(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);   // pool full
        repeat (5) tick();
        settle();

        // max lowered below count, then zero max via a wide write
        write_reg(REG_MAX_VOICES, 16'd1);
        add_voice(16'h1234, 16'hFFFF, 16'h1000, 16'h1000);
        tick();
        settle();
        write_reg(REG_MAX_VOICES, 16'h0200);
        write_reg(REG_SPARE, 16'h00FF);                       // unknown index
        add_voice(16'h1234, 16'hFFFF, 16'h1000, 16'h1000);
        tick();
        settle();

        // all retire at the top threshold, gain off
        write_reg(REG_THRESHOLD, 16'hFFFF);
        write_reg(REG_GAIN, 16'h0000);
        tick();
        settle();

        // fill every slot: the wide max value exceeds the slot count
        write_reg(REG_MAX_VOICES, 16'hFFFF);
        write_reg(REG_THRESHOLD, 16'h0000);
        write_reg(REG_GAIN, 16'd256);
        steady = 1'b1;
        for (n = 0; n < 258; n++) random_add();
        steady = 1'b0;
        repeat (3) tick();
        settle();
        write_reg(REG_THRESHOLD, 16'hFFFF);
        tick();
        settle();

        // random phases with varied register settings
        for (int ph = 0; ph < 12; ph++) begin
            pick = $urandom_range(3);
            write_reg(REG_GAIN, pick == 0 ? 16'h0000 : pick == 1 ? 16'hFFFF :
                                pick == 2 ? 16'd256 : 16'($urandom));
            pick = $urandom_range(3);
            write_reg(REG_THRESHOLD, pick == 0 ? 16'h0000 : pick == 1 ? 16'hFFFF :
                                     pick == 2 ? 16'd66 : 16'($urandom_range(0, 4000)));
            pick = $urandom_range(3);
            write_reg(REG_MAX_VOICES, pick == 0 ? 16'd1 : pick == 1 ? 16'd256 :
                                      16'($urandom_range(2, 40)));
            if ($urandom_range(5) == 0) write_reg(REG_SPARE, 16'($urandom));
            steady = (ph == 5);
            for (n = 0; n < 75; n++) begin
                if ($urandom_range(99) < 40) random_add();
                else tick();
                if (n == 40 && ph == 2) begin
                    // hold off until the block has caught up
                    @(negedge i_clk);
                    in_ch.valid = 1'b0;
                    while (pending != 0) @(negedge i_clk);
                end
            end
            steady = 1'b0;
            // every third phase, clear the pool before the next setting
            if (ph % 3 == 2) begin
                settle();
                write_reg(REG_THRESHOLD, 16'hFFFF);
                tick();
            end
            settle();
        end

        settle();
        repeat (20) @(negedge i_clk);
        if (fails == 0) begin
            $display("PASS impact_voice_mixer");
        end else begin
            $display("FAIL impact_voice_mixer");
        end
        $finish;
    end

endmodule
